// ===== hdl/wrs_pkg.sv =====
package wrs_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int PRICE_W     = 32;
    localparam int CHG_W       = PRICE_W + 1;
    localparam int CFG_W       = 7;
    localparam int WIN_W       = $clog2(MAX_WINDOW + 1);
    localparam int RING_AW     = $clog2(MAX_WINDOW);
    localparam int SUM_W       = PRICE_W + $clog2(MAX_WINDOW);
    localparam int RSI_W       = 14;
    localparam int PROD_W      = SUM_W + RSI_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int DIV_CNT_W   = $clog2(RSI_W);

    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(14);
    localparam logic [RSI_W-1:0] RSI_NEUTRAL  = RSI_W'(5000);
    localparam logic [RSI_W-1:0] RSI_SCALE    = RSI_W'(10000);

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic               restart;
    } wrs_in_t;

    typedef struct packed {
        logic [RSI_W-1:0] rsi_hundredths;
        logic             window_full;
    } wrs_out_t;

    typedef struct packed {
        logic [SUM_W-1:0] gain_sum;
        logic [SUM_W-1:0] loss_sum;
        logic             full;
    } wrs_job_t;

    typedef struct packed {
        logic     valid;
        wrs_job_t job;
    } wrs_push_t;

    typedef enum logic {
        F_IDLE,
        F_UPDATE
    } wrs_front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_DONE
    } wrs_back_state_t;

    function automatic logic [WIN_W-1:0] win_clamp(input logic [CFG_W-1:0] v);
        logic [WIN_W-1:0] w;
        w = WIN_W'(v);
        if (v == '0) begin
            w = WIN_W'(1);
        end else if (int'(v) > MAX_WINDOW) begin
            w = WIN_W'(MAX_WINDOW);
        end
        return w;
    endfunction

    function automatic logic [PRICE_W-1:0] gain_of(input logic [CHG_W-1:0] d);
        logic [PRICE_W-1:0] g;
        g = '0;
        if (!d[CHG_W-1]) begin
            g = d[PRICE_W-1:0];
        end
        return g;
    endfunction

    function automatic logic [PRICE_W-1:0] loss_of(input logic [CHG_W-1:0] d);
        logic [CHG_W-1:0]   neg;
        logic [PRICE_W-1:0] l;
        neg = -d;
        l   = '0;
        if (d[CHG_W-1]) begin
            l = neg[PRICE_W-1:0];
        end
        return l;
    endfunction

endpackage

// ===== hdl/wrs_ram.sv =====
module wrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/wrs_front.sv =====
module wrs_front import wrs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  wrs_in_t          s_data,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    output wrs_push_t        push,
    input  logic             queue_full
);

    wrs_front_state_t   state_reg, state_next;
    wrs_in_t            item_reg, item_next;
    logic [PRICE_W-1:0] prev_reg, prev_next;
    logic               have_prev_reg, have_prev_next;
    logic [RING_AW-1:0] pos_reg, pos_next;
    logic [WIN_W-1:0]   seen_reg, seen_next;
    logic [SUM_W-1:0]   gain_reg, gain_next;
    logic [SUM_W-1:0]   loss_reg, loss_next;
    logic [WIN_W-1:0]   win_reg, win_next;

    logic               accept;
    logic               fire;
    logic               base_have;
    logic [RING_AW-1:0] base_pos;
    logic [WIN_W-1:0]   base_seen;
    logic [SUM_W-1:0]   base_gain;
    logic [SUM_W-1:0]   base_loss;
    logic [CHG_W-1:0]   delta;
    logic [CHG_W-1:0]   old_chg;
    logic               evict;
    logic [WIN_W-1:0]   pos_inc;
    logic [RING_AW-1:0] upd_pos;
    logic [WIN_W-1:0]   upd_seen;
    logic [SUM_W-1:0]   upd_gain;
    logic [SUM_W-1:0]   upd_loss;
    logic               ring_we;

    wrs_ram #(
        .WIDTH (CHG_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ring_we),
        .wr_addr (base_pos),
        .wr_data (delta),
        .rd_addr (pos_reg),
        .rd_data (old_chg)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    state_next = F_UPDATE;
                end
            end
            F_UPDATE: begin
                if (!queue_full) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        fire    = 1'b0;
        case (state_reg)
            F_IDLE:   s_ready = 1'b1;
            F_UPDATE: fire    = !queue_full;
            default: begin
                s_ready = 1'b0;
                fire    = 1'b0;
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    always_comb begin
        base_have = item_reg.restart ? 1'b0 : have_prev_reg;
        base_pos  = item_reg.restart ? '0 : pos_reg;
        base_seen = item_reg.restart ? '0 : seen_reg;
        base_gain = item_reg.restart ? '0 : gain_reg;
        base_loss = item_reg.restart ? '0 : loss_reg;

        delta = {1'b0, item_reg.price} - {1'b0, prev_reg};
        evict = base_seen >= win_reg;

        upd_gain = base_gain + SUM_W'(gain_of(delta));
        upd_loss = base_loss + SUM_W'(loss_of(delta));
        if (evict) begin
            upd_gain = upd_gain - SUM_W'(gain_of(old_chg));
            upd_loss = upd_loss - SUM_W'(loss_of(old_chg));
        end
        upd_seen = evict ? base_seen : base_seen + WIN_W'(1);
        pos_inc  = WIN_W'(base_pos) + WIN_W'(1);
        upd_pos  = (pos_inc >= win_reg) ? '0 : pos_inc[RING_AW-1:0];

        if (!base_have) begin
            upd_gain = base_gain;
            upd_loss = base_loss;
            upd_seen = base_seen;
            upd_pos  = base_pos;
        end

        ring_we           = fire && base_have;
        push.valid        = fire;
        push.job.gain_sum = upd_gain;
        push.job.loss_sum = upd_loss;
        push.job.full     = upd_seen >= win_reg;
    end

    always_comb begin
        item_next      = accept ? s_data : item_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        pos_next       = pos_reg;
        seen_next      = seen_reg;
        gain_next      = gain_reg;
        loss_next      = loss_reg;
        win_next       = win_reg;
        if (cfg_wr_en) begin
            win_next       = win_clamp(cfg_wr_data);
            prev_next      = '0;
            have_prev_next = 1'b0;
            pos_next       = '0;
            seen_next      = '0;
            gain_next      = '0;
            loss_next      = '0;
        end else if (fire) begin
            prev_next      = item_reg.price;
            have_prev_next = 1'b1;
            pos_next       = upd_pos;
            seen_next      = upd_seen;
            gain_next      = upd_gain;
            loss_next      = upd_loss;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= F_IDLE;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            pos_reg       <= '0;
            seen_reg      <= '0;
            gain_reg      <= '0;
            loss_reg      <= '0;
            win_reg       <= win_clamp(WINDOW_RESET);
        end else begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
            gain_reg      <= gain_next;
            loss_reg      <= loss_next;
            win_reg       <= win_next;
        end
        item_reg <= item_next;
    end

endmodule

// ===== hdl/wrs_queue.sv =====
module wrs_queue import wrs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  wrs_push_t push,
    output logic      full,
    output logic      pop_valid,
    output wrs_job_t  pop_data,
    input  logic      pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    wrs_job_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push.valid && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule

// ===== hdl/wrs_back.sv =====
module wrs_back import wrs_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     job_valid,
    input  wrs_job_t job_data,
    output logic     job_pop,
    output logic     m_valid,
    input  logic     m_ready,
    output wrs_out_t m_data
);

    wrs_back_state_t    state_reg, state_next;
    logic [SUM_W-1:0]   gain_reg, gain_next;
    logic [SUM_W-1:0]   loss_reg, loss_next;
    logic [PROD_W-1:0]  rem_reg, rem_next;
    logic [PROD_W-1:0]  den_reg, den_next;
    logic [RSI_W-1:0]   quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic               full_reg, full_next;
    logic               m_valid_reg, m_valid_next;
    wrs_out_t           m_data_reg, m_data_next;

    logic               out_free;
    logic               take_job;
    logic               quick;
    logic               fits;
    logic [PROD_W-1:0]  rem_sub;
    logic [SUM_W:0]     den_sum;

    assign out_free = !m_valid_reg || m_ready;
    assign quick    = !job_data.full || (job_data.loss_sum == '0);
    assign fits     = rem_reg >= den_reg;
    assign rem_sub  = rem_reg - den_reg;
    assign den_sum  = {1'b0, gain_reg} + {1'b0, loss_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (job_valid) begin
                    state_next = quick ? B_DONE : B_MUL;
                end
            end
            B_MUL: state_next = B_DIV;
            B_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = B_DONE;
                end
            end
            B_DONE: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        take_job = 1'b0;
        case (state_reg)
            B_IDLE:  take_job = job_valid;
            default: take_job = 1'b0;
        endcase
    end

    assign job_pop = take_job;

    always_comb begin
        gain_next    = gain_reg;
        loss_next    = loss_reg;
        full_next    = full_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            B_IDLE: begin
                if (take_job) begin
                    gain_next = job_data.gain_sum;
                    loss_next = job_data.loss_sum;
                    full_next = job_data.full;
                    quo_next  = job_data.full ? RSI_SCALE : RSI_NEUTRAL;
                end
            end
            B_MUL: begin
                rem_next = PROD_W'(gain_reg) * PROD_W'(RSI_SCALE);
                den_next = PROD_W'(den_sum) << (RSI_W - 1);
                cnt_next = DIV_CNT_W'(RSI_W - 1);
                quo_next = '0;
            end
            B_DIV: begin
                if (fits) begin
                    rem_next = rem_sub;
                end
                quo_next = {quo_reg[RSI_W-2:0], fits};
                den_next = den_reg >> 1;
                cnt_next = cnt_reg - DIV_CNT_W'(1);
            end
            B_DONE: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_data_next.rsi_hundredths = quo_reg;
                    m_data_next.window_full    = full_reg;
                end
            end
            default: begin
                quo_next = quo_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        gain_reg   <= gain_next;
        loss_reg   <= loss_next;
        full_reg   <= full_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hdl/windowed_rsi_stream.sv =====
// Streaming RSI over a sliding window of price changes, simple average.
// Input channel s_*: one close price per transfer, with a restart flag that
// begins a new series. Result channel m_*: one RSI value in hundredths plus
// a window-full flag for every input transfer, in input order.
// cfg_wr_en/cfg_wr_data set the window length (0 acts as 1, values above 64
// act as 64) and clear the series history; write only while idle.
// Front: takes a transfer, then reads the change ring
// (64 x 33 RAM, one read and one write port) and updates the running sums
// before it takes the next price; it holds while the queue is full.
// Back: a 14-step restoring divider forms floor(10000*G/(G+L)); a full
// window with nonzero losses passes through load, multiply, the 14 divide
// steps and output, a warm-up or loss-free result only load and output.
// A two-entry queue separates front and back.
// The result sits in an output register; while the receiver stalls the
// back part holds its finished result and the queue fills, then s_ready
// drops. Reset (aresetn low, synchronous) sets window length 14 and clears
// the series; the ring RAM needs no clearing pass.
module windowed_rsi_stream import wrs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  wrs_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output wrs_out_t         m_data,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    wrs_push_t push;
    logic      queue_full;
    logic      job_valid;
    wrs_job_t  job_data;
    logic      job_pop;

    wrs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .queue_full  (queue_full)
    );

    wrs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .full      (queue_full),
        .pop_valid (job_valid),
        .pop_data  (job_data),
        .pop       (job_pop)
    );

    wrs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_data  (job_data),
        .job_pop   (job_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
